[rtl/valve_ack_motor_interlock_defines.svh]
// Assertion macros shared by the valve interlock RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef VALVE_ACK_MOTOR_INTERLOCK_DEFINES_SVH
`define VALVE_ACK_MOTOR_INTERLOCK_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VAMI_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define VAMI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vami_pkg.sv]
// Types, codes and helper functions for the valve interlock.
// Used by vami_eval and valve_ack_motor_interlock; no dependencies.
package vami_pkg;

    localparam logic [1:0] MODE_TICK      = 2'd0;
    localparam logic [1:0] MODE_ACK       = 2'd1;
    localparam logic [1:0] MODE_TARGET    = 2'd2;
    localparam logic [1:0] MODE_HEARTBEAT = 2'd3;

    localparam logic [2:0] STS_NONE       = 3'd0;
    localparam logic [2:0] STS_STARTED    = 3'd1;
    localparam logic [2:0] STS_PARTIAL    = 3'd2;
    localparam logic [2:0] STS_STOPPED    = 3'd3;
    localparam logic [2:0] STS_LATE_ACK   = 3'd4;
    localparam logic [2:0] STS_RESEND     = 3'd5;
    localparam logic [2:0] STS_EXHAUSTED  = 3'd6;

    localparam logic [1:0] REG_ACK_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT   = 2'd1;
    localparam logic [1:0] REG_FORCE_IVL     = 2'd2;
    localparam logic [1:0] REG_MAX_FORCE_RET = 2'd3;

    localparam logic [15:0] ACK_TIMEOUT_RST   = 16'd3000;
    localparam logic [3:0]  RETRY_LIMIT_RST   = 4'd5;
    localparam logic [15:0] FORCE_IVL_RST     = 16'd2000;
    localparam logic [3:0]  MAX_FORCE_RET_RST = 4'd10;
    localparam logic [15:0] LAST_ACK_RST      = 16'd9999;
    localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

    localparam logic [8:0] BIT_V1 = 9'd200;
    localparam logic [8:0] BIT_V2 = 9'd20;
    localparam logic [8:0] BIT_V3 = 9'd2;

    typedef struct packed {
        logic        motor_running;
        logic        fail_stopped;
        logic [9:0]  current_valves;
        logic [15:0] last_ack;
        logic        awaiting_ack;
        logic [15:0] ack_elapsed;
        logic [9:0]  last_sent;
        logic [3:0]  retry_count;
        logic        heartbeat_pending;
        logic        force_active;
        logic [3:0]  force_retries;
        logic [15:0] force_elapsed;
    } vami_state_t;

    typedef struct packed {
        logic [15:0] ack_timeout_ticks;
        logic [3:0]  retry_limit;
        logic [15:0] force_off_interval;
        logic [3:0]  force_retry_limit;
    } vami_cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] ack_value;
        logic [9:0]  target_signal;
        logic        manual_switching;
    } vami_item_t;

    typedef struct packed {
        logic       send_valid;
        logic [9:0] send_value;
        logic       force_off_send;
        logic       motor_on;
        logic       waiting_ack;
        logic       force_off_on;
        logic [2:0] status;
    } vami_result_t;

    // Confirmation bits expected for a three-digit valve signal. Division by
    // ten is a multiply by 205 and a shift, exact for values below 1024.
    function automatic logic [8:0] wanted_bits(input logic [9:0] sig);
        logic [17:0] p1;
        logic [6:0]  q;
        logic [14:0] p2;
        logic [3:0]  q10;
        logic [6:0]  tens;
        logic [9:0]  ones;
        logic [8:0]  r;
        p1   = {8'd0, sig} * 18'd205;
        q    = p1[17:11];
        p2   = {8'd0, q} * 15'd205;
        q10  = p2[14:11];
        tens = q - 7'({3'd0, q10} * 7'd10);
        ones = sig - 10'({3'd0, q} * 10'd10);
        r = 9'd0;
        if (sig >= 10'd100 && sig <= 10'd999) r = r | BIT_V1;
        if (tens != 7'd0) r = r | BIT_V2;
        if (ones != 10'd0) r = r | BIT_V3;
        return r;
    endfunction

    function automatic logic acceptable(input logic [9:0] sig, input logic [15:0] ack);
        logic [15:0] req;
        req = {7'd0, wanted_bits(sig)};
        if (sig == 10'd0) return ack == 16'd0;
        return ((ack & req) != 16'd0) && ((ack & ~req) == 16'd0);
    endfunction

endpackage

[rtl/vami_eval.sv]
// Single-pass event evaluation: next interlock state and one result beat.
// Depends on vami_pkg.
module vami_eval
(
    input  vami_pkg::vami_state_t  state,
    input  vami_pkg::vami_cfg_t    cfg,
    input  vami_pkg::vami_item_t   item,
    output vami_pkg::vami_state_t  state_next,
    output vami_pkg::vami_result_t result
);

    always_comb
    begin
        vami_pkg::vami_state_t n;
        logic       snd;
        logic [9:0] snd_val;
        logic       fsend;
        logic [2:0] st;
        logic       xmit;
        logic [9:0] xmit_val;

        n        = state;
        snd      = 1'b0;
        snd_val  = 10'd0;
        fsend    = 1'b0;
        st       = vami_pkg::STS_NONE;
        xmit     = 1'b0;
        xmit_val = 10'd0;

        case (item.mode)
            vami_pkg::MODE_TICK:
            begin
                if (state.awaiting_ack)
                begin
                    if (state.ack_elapsed != vami_pkg::COUNT_MAX)
                        n.ack_elapsed = state.ack_elapsed + 16'd1;
                    if (n.ack_elapsed >= cfg.ack_timeout_ticks)
                    begin
                        if (state.retry_count >= cfg.retry_limit)
                        begin
                            n.awaiting_ack      = 1'b0;
                            n.heartbeat_pending = 1'b0;
                            if (state.motor_running)
                            begin
                                n.motor_running = 1'b0;
                                n.fail_stopped  = 1'b1;
                            end
                            st = vami_pkg::STS_EXHAUSTED;
                        end
                        else
                        begin
                            n.retry_count = state.retry_count + 4'd1;
                            n.ack_elapsed = 16'd0;
                            snd           = 1'b1;
                            snd_val       = state.last_sent;
                            st            = vami_pkg::STS_RESEND;
                        end
                    end
                end
                if (state.force_active)
                begin
                    if (state.last_ack == 16'd0)
                    begin
                        n.force_active  = 1'b0;
                        n.force_retries = 4'd0;
                    end
                    else if (state.force_retries >= cfg.force_retry_limit)
                    begin
                        n.force_active = 1'b0;
                    end
                    else
                    begin
                        if (state.force_elapsed != vami_pkg::COUNT_MAX)
                            n.force_elapsed = state.force_elapsed + 16'd1;
                        if (n.force_elapsed >= cfg.force_off_interval)
                        begin
                            n.force_elapsed = 16'd0;
                            n.force_retries = state.force_retries + 4'd1;
                            fsend           = 1'b1;
                        end
                    end
                end
            end

            vami_pkg::MODE_ACK:
            begin
                n.last_ack     = item.ack_value;
                n.awaiting_ack = 1'b0;
                if (state.force_active)
                begin
                    if (item.ack_value == 16'd0)
                    begin
                        n.force_active  = 1'b0;
                        n.force_retries = 4'd0;
                    end
                end
                else if (state.heartbeat_pending)
                begin
                    n.heartbeat_pending = 1'b0;
                    if (state.motor_running)
                    begin
                        if (!vami_pkg::acceptable(state.current_valves, item.ack_value))
                        begin
                            n.motor_running = 1'b0;
                            xmit     = 1'b1;
                            xmit_val = state.current_valves;
                            st       = vami_pkg::STS_STOPPED;
                        end
                    end
                    else if (item.ack_value != 16'd0)
                    begin
                        n.force_active  = 1'b1;
                        n.force_retries = 4'd0;
                        n.force_elapsed = vami_pkg::COUNT_MAX;
                    end
                end
                else if (state.current_valves != 10'd0)
                begin
                    if (vami_pkg::acceptable(state.current_valves, item.ack_value))
                    begin
                        if (!state.motor_running)
                        begin
                            if (state.fail_stopped)
                            begin
                                n.fail_stopped = 1'b0;
                                st = vami_pkg::STS_LATE_ACK;
                            end
                            else
                            begin
                                n.motor_running = 1'b1;
                                if (item.ack_value ==
                                    {7'd0, vami_pkg::wanted_bits(state.current_valves)})
                                    st = vami_pkg::STS_STARTED;
                                else
                                    st = vami_pkg::STS_PARTIAL;
                            end
                        end
                    end
                    else if (item.ack_value == 16'd0 && state.motor_running)
                    begin
                        // A manual sequence closes valves on purpose.
                        if (!item.manual_switching)
                        begin
                            n.motor_running = 1'b0;
                            st = vami_pkg::STS_STOPPED;
                        end
                    end
                    else
                    begin
                        xmit     = 1'b1;
                        xmit_val = state.current_valves;
                        st       = vami_pkg::STS_RESEND;
                    end
                end
                else if (item.ack_value != 16'd0)
                begin
                    xmit     = 1'b1;
                    xmit_val = 10'd0;
                    st       = vami_pkg::STS_RESEND;
                end
            end

            vami_pkg::MODE_TARGET:
            begin
                if (item.target_signal != state.current_valves)
                begin
                    n.current_valves = item.target_signal;
                    if (item.target_signal == 10'd0 && state.motor_running)
                    begin
                        n.motor_running = 1'b0;
                        st = vami_pkg::STS_STOPPED;
                    end
                    xmit     = 1'b1;
                    xmit_val = item.target_signal;
                end
            end

            vami_pkg::MODE_HEARTBEAT:
            begin
                if (!state.force_active && !state.awaiting_ack)
                begin
                    n.heartbeat_pending = 1'b1;
                    xmit     = 1'b1;
                    xmit_val = state.motor_running ? state.current_valves : 10'd0;
                end
            end

            default:
            begin
                n = state;
            end
        endcase

        // A transmission restarts the acknowledgement wait.
        if (xmit)
        begin
            n.fail_stopped = 1'b0;
            n.last_sent    = xmit_val;
            n.awaiting_ack = 1'b1;
            n.ack_elapsed  = 16'd0;
            n.retry_count  = 4'd0;
            snd            = 1'b1;
            snd_val        = xmit_val;
        end

        state_next            = n;
        result.send_valid     = snd;
        result.send_value     = snd_val;
        result.force_off_send = fsend;
        result.motor_on       = n.motor_running;
        result.waiting_ack    = n.awaiting_ack;
        result.force_off_on   = n.force_active;
        result.status         = st;
    end

endmodule

[rtl/valve_ack_motor_interlock.sv]
// Pump motor interlock: each input beat yields exactly one result beat.
// An accepted beat is registered in the input stage, evaluated once the result register is free
// or is being drained, and then presented as a result beat from the result register.
// Throughput: one beat per cycle; input stalls only while a result waits on m_tready.
// Reset (rst_n low, asynchronous): state and config registers return to defaults,
// both stages empty.
module valve_ack_motor_interlock
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // ack_value[15:0], target_signal[25:16],
                                  // manual_switching[26], zero[31:27]
    input  logic [1:0]  s_tuser,  // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // send_valid[0], send_value[10:1], force_off_send[11],
                                  // motor_on[12], waiting_ack[13], force_off_on[14],
                                  // status[17:15], zero[23:18]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic                   in_valid_reg;
    vami_pkg::vami_item_t   in_item_reg;
    logic                   out_valid_reg;
    vami_pkg::vami_result_t out_reg;
    vami_pkg::vami_state_t  state_reg;
    vami_pkg::vami_state_t  state_next;
    vami_pkg::vami_cfg_t    cfg_reg;
    vami_pkg::vami_result_t result_next;
    logic                   stage_fire;

    assign stage_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || stage_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.mode             <= s_tuser;
            in_item_reg.ack_value        <= s_tdata[15:0];
            in_item_reg.target_signal    <= s_tdata[25:16];
            in_item_reg.manual_switching <= s_tdata[26];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_timeout_ticks  <= vami_pkg::ACK_TIMEOUT_RST;
            cfg_reg.retry_limit        <= vami_pkg::RETRY_LIMIT_RST;
            cfg_reg.force_off_interval <= vami_pkg::FORCE_IVL_RST;
            cfg_reg.force_retry_limit  <= vami_pkg::MAX_FORCE_RET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                vami_pkg::REG_ACK_TIMEOUT:   cfg_reg.ack_timeout_ticks  <= cfg_wdata;
                vami_pkg::REG_RETRY_LIMIT:   cfg_reg.retry_limit        <= cfg_wdata[3:0];
                vami_pkg::REG_FORCE_IVL:     cfg_reg.force_off_interval <= cfg_wdata;
                vami_pkg::REG_MAX_FORCE_RET: cfg_reg.force_retry_limit  <= cfg_wdata[3:0];
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    vami_eval u_eval
    (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.motor_running     <= 1'b0;
            state_reg.fail_stopped      <= 1'b0;
            state_reg.current_valves    <= 10'd0;
            state_reg.last_ack          <= vami_pkg::LAST_ACK_RST;
            state_reg.awaiting_ack      <= 1'b0;
            state_reg.ack_elapsed       <= 16'd0;
            state_reg.last_sent         <= 10'd0;
            state_reg.retry_count       <= 4'd0;
            state_reg.heartbeat_pending <= 1'b0;
            state_reg.force_active      <= 1'b0;
            state_reg.force_retries     <= 4'd0;
            state_reg.force_elapsed     <= 16'd0;
        end
        else if (stage_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.force_off_on, out_reg.waiting_ack,
                       out_reg.motor_on, out_reg.force_off_send, out_reg.send_value,
                       out_reg.send_valid};

`include "valve_ack_motor_interlock_defines.svh"

    // A motor stopped by exhausted retries stays off until a new send or late ack.
    `VAMI_ASSERT_IMPLY(a_fail_motor_off, state_reg.fail_stopped, !state_reg.motor_running, "fail_stopped with motor running")
    // Every evaluated event lands in the result register.
    `VAMI_ASSERT_NEXT(a_fire_loads_out, stage_fire, out_valid_reg, "evaluated event lost")
    // A resend status always carries a transmitted signal.
    `VAMI_ASSERT_IMPLY(a_resend_sends, out_valid_reg && out_reg.status == vami_pkg::STS_RESEND, out_reg.send_valid, "resend without send")

endmodule

[sim/tb_valve_ack_motor_interlock.sv]
// Self-checking testbench for the pump motor interlock: a directed table, then random phases.
// Results are predicted in-bench and compared beat by beat; depends on vami_pkg and the RTL.
`timescale 1ns / 1ps

module tb_valve_ack_motor_interlock;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // ack_value[15:0], target_signal[25:16], manual_switching[26]
    logic [1:0]  s_tuser;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // send_valid[0], send_value[10:1], force_off_send[11],
                            // motor_on[12], waiting_ack[13], force_off_on[14], status[17:15]
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    valve_ack_motor_interlock dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    typedef struct packed {
        logic                   is_cfg;
        logic [1:0]             cfg_index;
        logic [15:0]            cfg_value;
        vami_pkg::vami_item_t   item;
        logic                   typed;
        vami_pkg::vami_result_t want;
    } stim_row_t;

    // Interlock state as the predictor sees it.
    logic        motor;
    logic        fail_latch;
    logic [9:0]  valves;
    logic [15:0] ack_seen;
    logic        ack_open;
    logic [15:0] ack_age;
    logic [9:0]  sent_sig;
    logic [3:0]  retry_cnt;
    logic        hb_open;
    logic        frc_on;
    logic [3:0]  frc_cnt;
    logic [15:0] frc_age;
    logic [15:0] lim_timeout;
    logic [3:0]  lim_retries;
    logic [15:0] lim_force_ivl;
    logic [3:0]  lim_force;
    logic        snd_on;
    logic [9:0]  snd_word;

    vami_pkg::vami_result_t due_reports[$];
    stim_row_t              directed_rows[$];
    int                     mismatches;
    int                     beats_offered;
    logic                   tx_idle;
    logic                   rx_idle;
    int                     rx_hold;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [15:0] confirm_bits(input logic [9:0] sig);
        int unsigned s;
        logic [15:0] r;
        s = sig;
        r = 16'd0;
        if (((s / 100) % 10) != 0) r = r + 16'd200;
        if (((s / 10) % 10) != 0) r = r + 16'd20;
        if ((s % 10) != 0) r = r + 16'd2;
        return r;
    endfunction

    function automatic logic ack_fits(input logic [9:0] sig, input logic [15:0] ack);
        logic [15:0] req;
        req = confirm_bits(sig);
        if (sig == 10'd0) return ack == 16'd0;
        return ((ack & req) != 16'd0) && ((ack & ~req) == 16'd0);
    endfunction

    function automatic void send_signal(input logic [9:0] sig);
        fail_latch = 1'b0;
        sent_sig   = sig;
        ack_open   = 1'b1;
        ack_age    = 16'd0;
        retry_cnt  = 4'd0;
        snd_on     = 1'b1;
        snd_word   = sig;
    endfunction

    function automatic vami_pkg::vami_result_t next_interlock_report(
        input vami_pkg::vami_item_t it);
        logic [2:0]             st;
        logic                   fsend;
        vami_pkg::vami_result_t r;
        st = vami_pkg::STS_NONE;
        fsend = 1'b0;
        snd_on = 1'b0;
        snd_word = 10'd0;
        case (it.mode)
            vami_pkg::MODE_TICK:
            begin
                if (ack_open)
                begin
                    if (ack_age != vami_pkg::COUNT_MAX) ack_age = ack_age + 16'd1;
                    if (ack_age >= lim_timeout)
                    begin
                        if (retry_cnt >= lim_retries)
                        begin
                            ack_open = 1'b0;
                            hb_open = 1'b0;
                            if (motor)
                            begin
                                motor = 1'b0;
                                fail_latch = 1'b1;
                            end
                            st = vami_pkg::STS_EXHAUSTED;
                        end
                        else
                        begin
                            retry_cnt = retry_cnt + 4'd1;
                            ack_age = 16'd0;
                            snd_on = 1'b1;
                            snd_word = sent_sig;
                            st = vami_pkg::STS_RESEND;
                        end
                    end
                end
                // The force-off step runs after the retry step on the same tick.
                if (frc_on)
                begin
                    if (ack_seen == 16'd0)
                    begin
                        frc_on = 1'b0;
                        frc_cnt = 4'd0;
                    end
                    else if (frc_cnt >= lim_force)
                    begin
                        frc_on = 1'b0;
                    end
                    else
                    begin
                        if (frc_age != vami_pkg::COUNT_MAX) frc_age = frc_age + 16'd1;
                        if (frc_age >= lim_force_ivl)
                        begin
                            frc_age = 16'd0;
                            frc_cnt = frc_cnt + 4'd1;
                            fsend = 1'b1;
                        end
                    end
                end
            end
            vami_pkg::MODE_ACK:
            begin
                ack_seen = it.ack_value;
                ack_open = 1'b0;
                if (frc_on)
                begin
                    if (it.ack_value == 16'd0)
                    begin
                        frc_on = 1'b0;
                        frc_cnt = 4'd0;
                    end
                end
                else if (hb_open)
                begin
                    hb_open = 1'b0;
                    if (motor)
                    begin
                        if (!ack_fits(valves, it.ack_value))
                        begin
                            motor = 1'b0;
                            send_signal(valves);
                            st = vami_pkg::STS_STOPPED;
                        end
                    end
                    else if (it.ack_value != 16'd0)
                    begin
                        // First close word goes out on the next tick unless the force retry limit is zero.
                        frc_on = 1'b1;
                        frc_cnt = 4'd0;
                        frc_age = vami_pkg::COUNT_MAX;
                    end
                end
                else if (valves != 10'd0)
                begin
                    if (ack_fits(valves, it.ack_value))
                    begin
                        if (!motor)
                        begin
                            if (fail_latch)
                            begin
                                fail_latch = 1'b0;
                                st = vami_pkg::STS_LATE_ACK;
                            end
                            else
                            begin
                                motor = 1'b1;
                                st = (it.ack_value == confirm_bits(valves))
                                     ? vami_pkg::STS_STARTED : vami_pkg::STS_PARTIAL;
                            end
                        end
                    end
                    else if (it.ack_value == 16'd0 && motor)
                    begin
                        if (!it.manual_switching)
                        begin
                            motor = 1'b0;
                            st = vami_pkg::STS_STOPPED;
                        end
                    end
                    else
                    begin
                        send_signal(valves);
                        st = vami_pkg::STS_RESEND;
                    end
                end
                else if (it.ack_value != 16'd0)
                begin
                    send_signal(10'd0);
                    st = vami_pkg::STS_RESEND;
                end
            end
            vami_pkg::MODE_TARGET:
            begin
                if (it.target_signal != valves)
                begin
                    valves = it.target_signal;
                    if (it.target_signal == 10'd0)
                    begin
                        if (motor)
                        begin
                            motor = 1'b0;
                            st = vami_pkg::STS_STOPPED;
                        end
                        send_signal(10'd0);
                    end
                    else
                    begin
                        send_signal(it.target_signal);
                    end
                end
            end
            default:
            begin
                if (!frc_on && !ack_open)
                begin
                    hb_open = 1'b1;
                    send_signal(motor ? valves : 10'd0);
                end
            end
        endcase
        r.send_valid     = snd_on;
        r.send_value     = snd_on ? snd_word : 10'd0;
        r.force_off_send = fsend;
        r.motor_on       = motor;
        r.waiting_ack    = ack_open;
        r.force_off_on   = frc_on;
        r.status         = st;
        return r;
    endfunction

    function automatic vami_pkg::vami_result_t report(input logic sv, input logic [9:0] sval,
                                            input logic fs, input logic mo, input logic wa,
                                            input logic fo, input logic [2:0] st);
        vami_pkg::vami_result_t r;
        r.send_valid     = sv;
        r.send_value     = sval;
        r.force_off_send = fs;
        r.motor_on       = mo;
        r.waiting_ack    = wa;
        r.force_off_on   = fo;
        r.status         = st;
        return r;
    endfunction

    function automatic void add_checked(input logic [1:0] mode, input logic [15:0] ack,
                                        input logic [9:0] tgt, input logic man,
                                        input logic typed,
                                        input vami_pkg::vami_result_t want);
        stim_row_t row;
        row = '0;
        row.item.mode             = mode;
        row.item.ack_value        = ack;
        row.item.target_signal    = tgt;
        row.item.manual_switching = man;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_event(input logic [1:0] mode, input logic [15:0] ack,
                                      input logic [9:0] tgt, input logic man);
        add_checked(mode, ack, tgt, man, 1'b0, '0);
    endfunction

    function automatic void add_setting(input logic [1:0] idx, input logic [15:0] val);
        stim_row_t row;
        row = '0;
        row.is_cfg    = 1'b1;
        row.cfg_index = idx;
        row.cfg_value = val;
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned seen);
        if (want != seen)
        begin
            $error("%s: expected %0d, actual %0d", name, want, seen);
            mismatches++;
        end
    endfunction

    function automatic logic [15:0] fitting_ack();
        logic [15:0] req;
        logic [15:0] a;
        req = confirm_bits(valves);
        a = req & 16'($urandom);
        if (a == 16'd0) a = req;
        // Now and then a stray bit spoils the word.
        if ($urandom_range(0, 5) == 0) a = a | (16'd1 << $urandom_range(0, 15));
        return a;
    endfunction

    function automatic logic [9:0] pick_target();
        case ($urandom_range(0, 15))
            0: return 10'd0;
            1: return 10'($urandom_range(1000, 1023));
            2: return valves;
            default: return 10'($urandom_range(1, 999));
        endcase
    endfunction

    // Offers one beat; returns at the falling edge after it was accepted, with valid still up.
    task automatic drive_event(input vami_pkg::vami_item_t it, input logic typed,
                               input vami_pkg::vami_result_t want);
        int gap;
        vami_pkg::vami_result_t predicted;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {5'd0, it.manual_switching, it.target_signal, it.ack_value};
        s_tuser  = it.mode;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        predicted = next_interlock_report(it);
        due_reports.push_back(typed ? want : predicted);
        beats_offered++;
        @(negedge clk);
    endtask

    task automatic offer(input logic [1:0] mode, input logic [15:0] ack,
                         input logic [9:0] tgt, input logic man);
        vami_pkg::vami_item_t it;
        it.mode             = mode;
        it.ack_value        = ack;
        it.target_signal    = tgt;
        it.manual_switching = man;
        drive_event(it, 1'b0, '0);
    endtask

    task automatic settle_block();
        s_tvalid = 1'b0;
        do @(negedge clk); while (due_reports.size() != 0);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        case (idx)
            vami_pkg::REG_ACK_TIMEOUT:   lim_timeout = val;
            vami_pkg::REG_RETRY_LIMIT:   lim_retries = val[3:0];
            vami_pkg::REG_FORCE_IVL:     lim_force_ivl = val;
            vami_pkg::REG_MAX_FORCE_RET: lim_force = val[3:0];
            default:                     lim_timeout = lim_timeout;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Mostly well-formed exchanges: a target and its ack, tick runs that can reach the
    // timeouts, heartbeats with their replies; the rest is noise.
    task automatic random_exchange();
        int n;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                offer(vami_pkg::MODE_TARGET, 16'($urandom), pick_target(), 1'($urandom));
                if ($urandom_range(0, 2) != 0)
                    offer(vami_pkg::MODE_ACK, fitting_ack(), 10'($urandom), 1'($urandom));
            end
            2, 3: offer(vami_pkg::MODE_ACK, fitting_ack(), 10'($urandom), 1'($urandom));
            4:
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                    offer(vami_pkg::MODE_TICK, 16'($urandom), 10'($urandom), 1'($urandom));
            end
            5:
            begin
                offer(vami_pkg::MODE_HEARTBEAT, 16'($urandom), 10'($urandom), 1'($urandom));
                case ($urandom_range(0, 2))
                    0: offer(vami_pkg::MODE_ACK, fitting_ack(), 10'($urandom), 1'($urandom));
                    1: offer(vami_pkg::MODE_ACK, 16'd0, 10'($urandom), 1'($urandom));
                    default:
                        offer(vami_pkg::MODE_ACK, 16'($urandom), 10'($urandom),
                              1'($urandom));
                endcase
            end
            6: offer(vami_pkg::MODE_ACK, 16'd0, 10'($urandom), 1'($urandom));
            7, 8: offer(2'($urandom), 16'($urandom), 10'($urandom), 1'($urandom));
            default:
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    offer(vami_pkg::MODE_TICK, 16'($urandom), 10'($urandom), 1'($urandom));
                offer(vami_pkg::MODE_ACK, fitting_ack(), 10'($urandom), 1'($urandom));
            end
        endcase
    endtask

    task automatic run_phase(input logic [15:0] tmo, input logic [15:0] rtr,
                             input logic [15:0] ivl, input logic [15:0] frt, input int beats,
                             input logic tx, input logic rx, input int hold);
        int stop_at;
        settle_block();
        cfg_write(vami_pkg::REG_ACK_TIMEOUT, tmo);
        cfg_write(vami_pkg::REG_RETRY_LIMIT, rtr);
        cfg_write(vami_pkg::REG_FORCE_IVL, ivl);
        cfg_write(vami_pkg::REG_MAX_FORCE_RET, frt);
        tx_idle = tx;
        rx_idle = rx;
        rx_hold = hold;
        stop_at = beats_offered + beats;
        while (beats_offered < stop_at) random_exchange();
    endtask

    initial
    begin : result_sink
        int gap;
        vami_pkg::vami_result_t seen;
        vami_pkg::vami_result_t want;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = rx_idle ? $urandom_range(0, 19) : 0;
            if (rx_hold > 0)
            begin
                gap = rx_hold;
                rx_hold = 0;
            end
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            seen.send_valid     = m_tdata[0];
            seen.send_value     = m_tdata[10:1];
            seen.force_off_send = m_tdata[11];
            seen.motor_on       = m_tdata[12];
            seen.waiting_ack    = m_tdata[13];
            seen.force_off_on   = m_tdata[14];
            seen.status         = m_tdata[17:15];
            if (due_reports.size() == 0)
            begin
                $error("result beat 0x%h arrived with nothing predicted", m_tdata);
                mismatches++;
            end
            else
            begin
                want = due_reports.pop_front();
                check_field("send_valid", want.send_valid, seen.send_valid);
                check_field("send_value", want.send_value, seen.send_value);
                check_field("force_off_send", want.force_off_send, seen.force_off_send);
                check_field("motor_on", want.motor_on, seen.motor_on);
                check_field("waiting_ack", want.waiting_ack, seen.waiting_ack);
                check_field("force_off_on", want.force_off_on, seen.force_off_on);
                check_field("status", want.status, seen.status);
            end
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 32'd0;
        s_tuser   = vami_pkg::MODE_TICK;
        cfg_we    = 1'b0;
        cfg_addr  = vami_pkg::REG_ACK_TIMEOUT;
        cfg_wdata = 16'd0;
        tx_idle   = 1'b1;
        rx_idle   = 1'b1;
        rx_hold   = 0;
        mismatches    = 0;
        beats_offered = 0;

        motor         = 1'b0;
        fail_latch    = 1'b0;
        valves        = 10'd0;
        ack_seen      = vami_pkg::LAST_ACK_RST;
        ack_open      = 1'b0;
        ack_age       = 16'd0;
        sent_sig      = 10'd0;
        retry_cnt     = 4'd0;
        hb_open       = 1'b0;
        frc_on        = 1'b0;
        frc_cnt       = 4'd0;
        frc_age       = 16'd0;
        lim_timeout   = vami_pkg::ACK_TIMEOUT_RST;
        lim_retries   = vami_pkg::RETRY_LIMIT_RST;
        lim_force_ivl = vami_pkg::FORCE_IVL_RST;
        lim_force     = vami_pkg::MAX_FORCE_RET_RST;

        // Rows with a typed report are checked against it; the predictor still tracks them.
        // Reset settings: a heartbeat answered by a nonzero word starts force-off.
        add_checked(vami_pkg::MODE_TICK, 16'd0, 10'd0, 1'b0, 1'b1,
                    report(1'b0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, vami_pkg::STS_NONE));
        add_checked(vami_pkg::MODE_HEARTBEAT, 16'hFFFF, 10'h3FF, 1'b1, 1'b1,
                    report(1'b1, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0, vami_pkg::STS_NONE));
        add_event(vami_pkg::MODE_ACK, 16'hFFFF, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_TICK, 16'd0, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_ACK, 16'd0, 10'd0, 1'b1);
        // Short timeout, one retry, one force-off resend; upper bits of the 4-bit
        // registers are junk and must be dropped.
        add_setting(vami_pkg::REG_ACK_TIMEOUT, 16'd2);
        add_setting(vami_pkg::REG_RETRY_LIMIT, 16'hABC1);
        add_setting(vami_pkg::REG_FORCE_IVL, 16'd1);
        add_setting(vami_pkg::REG_MAX_FORCE_RET, 16'h0001);
        add_event(vami_pkg::MODE_TARGET, 16'd0, 10'd123, 1'b0);
        add_checked(vami_pkg::MODE_ACK, 16'd222, 10'd0, 1'b0, 1'b1,
                    report(1'b0, 10'd0, 1'b0, 1'b1, 1'b0, 1'b0, vami_pkg::STS_STARTED));
        add_event(vami_pkg::MODE_TARGET, 16'd0, 10'd123, 1'b0);
        add_event(vami_pkg::MODE_ACK, 16'd0, 10'd0, 1'b1);
        add_event(vami_pkg::MODE_TARGET, 16'd0, 10'd1023, 1'b0);
        add_event(vami_pkg::MODE_TICK, 16'd0, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_TICK, 16'd0, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_TICK, 16'd0, 10'd0, 1'b0);
        add_checked(vami_pkg::MODE_TICK, 16'd0, 10'd0, 1'b0, 1'b1,
                    report(1'b0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, vami_pkg::STS_EXHAUSTED));
        add_checked(vami_pkg::MODE_ACK, 16'd22, 10'd0, 1'b0, 1'b1,
                    report(1'b0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, vami_pkg::STS_LATE_ACK));
        add_event(vami_pkg::MODE_ACK, 16'h0100, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_ACK, 16'd20, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_HEARTBEAT, 16'd0, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_ACK, 16'h8000, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_ACK, 16'd22, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_ACK, 16'd0, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_ACK, 16'd22, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_TARGET, 16'd0, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_ACK, 16'd1, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_ACK, 16'd0, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_HEARTBEAT, 16'd0, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_ACK, 16'd3, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_TICK, 16'd0, 10'd0, 1'b0);
        add_event(vami_pkg::MODE_TICK, 16'd0, 10'd0, 1'b0);

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                settle_block();
                cfg_write(directed_rows[i].cfg_index, directed_rows[i].cfg_value);
            end
            else
            begin
                drive_event(directed_rows[i].item, directed_rows[i].typed,
                            directed_rows[i].want);
            end
        end

        run_phase(16'd1, 16'd0, 16'd1, 16'd0, 108, 1'b1, 1'b1, 0);
        // Back-to-back beats against a long receiver stall fill the pipeline.
        run_phase(16'hFFFF, 16'd15, 16'hFFFF, 16'hFFFF, 108, 1'b0, 1'b0, 80);
        for (k = 0; k < 4; k++)
        begin
            run_phase(16'($urandom_range(1, 12)),
                      (16'($urandom) & 16'hFFF0) | 16'($urandom_range(0, 3)),
                      16'($urandom_range(1, 8)),
                      (16'($urandom) & 16'hFFF0) | 16'($urandom_range(0, 15)),
                      108, k != 2, k != 1, 0);
        end

        s_tvalid = 1'b0;
        while (due_reports.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/vami_pkg.sv
rtl/vami_eval.sv
rtl/valve_ack_motor_interlock.sv
sim/tb_valve_ack_motor_interlock.sv
